/* hdl/kmsd_pkg.sv */
// Shared types, constants and helper functions for the key matrix scan debouncer.
package kmsd_pkg;

	// Matrix geometry.
	localparam int ROWS = 8;
	localparam int ROW_W = 12;
	localparam int ROW_IDX_W = 3;
	localparam int NATIVE_W = 7;
	localparam int EXP_W = 8;
	localparam int NATIVE_SHIFT = 5;
	localparam int EXP_USED_W = 7;

	// Counter widths.
	localparam int CNT_W = $clog2(ROWS * ROW_W + 1);
	localparam int POP_W = $clog2(ROW_W + 1);
	localparam int KEY_CNT_W = 7;
	localparam int KEY_CNT_MAX = 127;
	localparam int TICK_W = 16;
	localparam int DELAY_W = 8;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd5;

	// Stream packing.
	localparam int KIND_W = 2;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	// Item kinds carried on the input tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_EOS    = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef logic [ROW_W-1:0] row_word_t;

	// Number of set bits in one row word.
	function automatic logic [POP_W-1:0] pop_row(input row_word_t w);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < ROW_W; i++) begin
			n = n + POP_W'(w[i]);
		end
		return n;
	endfunction

	// Build a row word from native pins (active low) and expander columns.
	function automatic row_word_t build_row(
		input logic [NATIVE_W-1:0] native,
		input logic [EXP_W-1:0]    expander,
		input logic                ok
	);
		row_word_t w;
		w = '0;
		w[NATIVE_SHIFT +: NATIVE_W] = ~native;
		if (ok) begin
			w[EXP_USED_W-1:0] = w[EXP_USED_W-1:0] | expander[EXP_USED_W-1:0];
		end
		return w;
	endfunction

endpackage

/* hdl/key_matrix_scan_debouncer_top.sv */
// Top level of the key matrix scan debouncer: input stage, matrix state and result register.
//
// Usage:
//   Items enter on the s_* stream. s_tuser holds the kind (row sample, millisecond
//   tick, end of scan, stable row read); s_tdata holds row index and column data.
//   Every item produces exactly one result on the m_* stream: stable row data for a
//   read, the row-changed and committed flags, the settled flag and the key count.
//   The debounce delay is written through cfg_we / cfg_wdata while the block is idle.
// Pipeline and throughput:
//   An accepted item is held in the input register, and when the output register is
//   free or draining its result is registered there and m_tvalid rises. One item is
//   taken every cycle while m_tready stays high; the single update path between the
//   input register and the result register carries each item.
// Reset:
//   arst_n clears both row matrices, the pending flag, the quiet counter and the key
//   counts, and sets the debounce delay to 5 ticks. Both streams come up empty.
// Stalls:
//   When m_tready is low the result holds in the output register and the input
//   register keeps its item; s_tready drops only while both are full.
module key_matrix_scan_debouncer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: row_index[2:0], native_cols[9:3], exp_cols[17:10],
	// expander_ok[18], zero fill [23:19].
	input  logic [kmsd_pkg::S_DATA_W-1:0]    s_tdata,
	// s_tuser: kind[1:0].
	input  logic [kmsd_pkg::KIND_W-1:0]      s_tuser,
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: row_data[11:0], row_changed[12], committed[13], settled[14],
	// key_count[21:15], zero fill [23:22].
	output logic [kmsd_pkg::M_DATA_W-1:0]    m_tdata,
	// Configuration write.
	input  logic                             cfg_we,
	input  logic [kmsd_pkg::DELAY_W-1:0]     cfg_wdata
);

	// Input register.
	logic                                  valid_s1;
	kmsd_pkg::kind_t                       kind_s1;
	logic [kmsd_pkg::ROW_IDX_W-1:0]        row_s1;
	logic [kmsd_pkg::NATIVE_W-1:0]         native_s1;
	logic [kmsd_pkg::EXP_W-1:0]            exp_s1;
	logic                                  ok_s1;

	// Matrix state.
	kmsd_pkg::row_word_t                   sampled_q [kmsd_pkg::ROWS];
	kmsd_pkg::row_word_t                   stable_q  [kmsd_pkg::ROWS];
	logic                                  pending_q;
	logic [kmsd_pkg::TICK_W-1:0]           quiet_q;
	logic [kmsd_pkg::CNT_W-1:0]            sampled_count_q;
	logic [kmsd_pkg::CNT_W-1:0]            stable_count_q;
	logic [kmsd_pkg::DELAY_W-1:0]          delay_q;

	// Result register.
	logic                                  out_valid_q;
	logic [kmsd_pkg::M_DATA_W-1:0]         out_data_q;

	// Update path signals.
	logic                                  advance;
	logic                                  row_ok;
	kmsd_pkg::row_word_t                   new_row;
	kmsd_pkg::row_word_t                   old_sampled;
	kmsd_pkg::row_word_t                   old_stable;
	logic                                  do_sample;
	logic                                  do_direct;
	logic                                  do_commit;
	logic                                  row_changed;
	logic                                  committed;
	logic                                  pending_d;
	logic [kmsd_pkg::TICK_W-1:0]           quiet_d;
	logic [kmsd_pkg::CNT_W-1:0]            sampled_count_d;
	logic [kmsd_pkg::CNT_W-1:0]            stable_count_d;
	logic [kmsd_pkg::ROW_W-1:0]            row_data;
	logic [kmsd_pkg::KEY_CNT_W-1:0]        key_count;
	logic [kmsd_pkg::M_DATA_W-1:0]         result;

	// Handshake: the input stage moves whenever the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1   <= kmsd_pkg::kind_t'(s_tuser);
			row_s1    <= s_tdata[2:0];
			native_s1 <= s_tdata[9:3];
			exp_s1    <= s_tdata[17:10];
			ok_s1     <= s_tdata[18];
		end
	end

	// Per-item update of the matrix state and the result word.
	always_comb begin
		row_ok      = (32'(row_s1) < kmsd_pkg::ROWS);
		new_row     = kmsd_pkg::build_row(native_s1, exp_s1, ok_s1);
		old_sampled = sampled_q[row_s1];
		old_stable  = stable_q[row_s1];

		do_sample   = (kind_s1 == kmsd_pkg::KIND_SAMPLE) && row_ok;
		do_direct   = do_sample && (delay_q == '0);
		row_changed = do_sample && (new_row != old_sampled);
		do_commit   = (kind_s1 == kmsd_pkg::KIND_EOS) && pending_q &&
			(quiet_q > kmsd_pkg::TICK_W'(delay_q));

		pending_d       = pending_q;
		quiet_d         = quiet_q;
		sampled_count_d = sampled_count_q;
		stable_count_d  = stable_count_q;
		committed       = 1'b0;
		row_data        = '0;

		unique case (kind_s1)
			kmsd_pkg::KIND_SAMPLE: begin
				if (do_sample) begin
					sampled_count_d = sampled_count_q
						- kmsd_pkg::CNT_W'(kmsd_pkg::pop_row(old_sampled))
						+ kmsd_pkg::CNT_W'(kmsd_pkg::pop_row(new_row));
					if (do_direct) begin
						committed      = (new_row != old_stable);
						stable_count_d = stable_count_q
							- kmsd_pkg::CNT_W'(kmsd_pkg::pop_row(old_stable))
							+ kmsd_pkg::CNT_W'(kmsd_pkg::pop_row(new_row));
					end else if (row_changed) begin
						pending_d = 1'b1;
						quiet_d   = '0;
					end
				end
			end
			kmsd_pkg::KIND_TICK: begin
				if (quiet_q != '1) begin
					quiet_d = quiet_q + 1'b1;
				end
			end
			kmsd_pkg::KIND_EOS: begin
				if (do_commit) begin
					stable_count_d = sampled_count_q;
					pending_d      = 1'b0;
					committed      = 1'b1;
				end
			end
			kmsd_pkg::KIND_READ: begin
				if (row_ok) begin
					row_data = old_stable;
				end
			end
			default: begin
			end
		endcase

		// Saturate the reported key count.
		if (stable_count_d > kmsd_pkg::CNT_W'(kmsd_pkg::KEY_CNT_MAX)) begin
			key_count = kmsd_pkg::KEY_CNT_W'(kmsd_pkg::KEY_CNT_MAX);
		end else begin
			key_count = kmsd_pkg::KEY_CNT_W'(stable_count_d);
		end

		result = {2'b00, key_count, !pending_d, committed, row_changed, row_data};
	end

	// Control state: flags, counters and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q       <= 1'b0;
			quiet_q         <= '0;
			sampled_count_q <= '0;
			stable_count_q  <= '0;
			delay_q         <= kmsd_pkg::DELAY_RESET;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			if (advance) begin
				pending_q       <= pending_d;
				quiet_q         <= quiet_d;
				sampled_count_q <= sampled_count_d;
				stable_count_q  <= stable_count_d;
			end
		end
	end

	// Row matrices: single-row writes on samples, whole-matrix copy on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < kmsd_pkg::ROWS; r++) begin
				sampled_q[r] <= '0;
				stable_q[r]  <= '0;
			end
		end else if (advance) begin
			if (do_sample) begin
				sampled_q[row_s1] <= new_row;
			end
			if (do_direct) begin
				stable_q[row_s1] <= new_row;
			end else if (do_commit) begin
				for (int r = 0; r < kmsd_pkg::ROWS; r++) begin
					stable_q[r] <= sampled_q[r];
				end
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

`ifndef NO_ASSERTIONS
	// An empty result register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("s_tready low while the result register is empty");

	// A commit at end of scan clears the pending debounce.
	a_commit_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && do_commit) |=> !pending_q)
		else $error("pending still set after an end-of-scan commit");

	// A changed row with debouncing on restarts the quiet counter.
	a_change_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && row_changed && !do_direct) |=> (pending_q && quiet_q == '0))
		else $error("changed row did not restart the debounce");

	// The stable key count never exceeds the matrix size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stable_count_q <= kmsd_pkg::CNT_W'(kmsd_pkg::ROWS * kmsd_pkg::ROW_W))
		else $error("stable key count out of range");

	// A reported commit always comes with the settled flag or a direct write.
	a_commit_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && committed && !do_direct) |-> !pending_d)
		else $error("end-of-scan commit reported while still pending");
`endif

endmodule
